[src/cacr_pkg.sv]
// Package: sequencer state codes and shared constants for the crop rectangle block.
`timescale 1ns / 1ps
package cacr_pkg;

  localparam int unsigned StW = 5;

  localparam logic [StW-1:0] S_IDLE      = 5'd0;
  localparam logic [StW-1:0] S_CHK       = 5'd1;
  localparam logic [StW-1:0] S_DIV       = 5'd2;
  localparam logic [StW-1:0] S_CW_CHK    = 5'd3;
  localparam logic [StW-1:0] S_CH_CHK    = 5'd4;
  localparam logic [StW-1:0] S_EDGE_INIT = 5'd5;
  localparam logic [StW-1:0] S_R_INIT    = 5'd6;
  localparam logic [StW-1:0] S_R_LOOP    = 5'd7;
  localparam logic [StW-1:0] S_R_STEP    = 5'd8;
  localparam logic [StW-1:0] S_R_N       = 5'd9;
  localparam logic [StW-1:0] S_R_D       = 5'd10;
  localparam logic [StW-1:0] S_COMB      = 5'd11;
  localparam logic [StW-1:0] S_M0        = 5'd12;
  localparam logic [StW-1:0] S_M1        = 5'd13;
  localparam logic [StW-1:0] S_M2        = 5'd14;
  localparam logic [StW-1:0] S_M3        = 5'd15;
  localparam logic [StW-1:0] S_SUM       = 5'd16;
  localparam logic [StW-1:0] S_AFTER     = 5'd17;
  localparam logic [StW-1:0] S_FINAL     = 5'd18;
  localparam logic [StW-1:0] S_DONE      = 5'd19;

  typedef logic [StW-1:0] state_t;

  localparam logic [4:0] DIV_LAST_STEP = 5'd31;

endpackage

[src/clean_aperture_crop_rect.sv]
// Top level: clean-aperture fractions to crop rectangle, one shared serial divider.
// Flow: each divide loads its operands, then runs 32 radix-2 restoring steps. A header
//   rejected on its fields goes from S_CHK straight to S_DONE; a full item runs two size
//   divides plus six GCD reductions of up to ~47 Euclid steps each.
// Throughput: one item at a time; the next beat is taken the cycle after the result is staged.
// Reset: synchronous active-low rst_n idles the sequencer and drops out_valid.
`timescale 1ns / 1ps
module clean_aperture_crop_rect
  import cacr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_image_width,
  input  logic [31:0]        in_image_height,
  input  logic signed [31:0] in_width_num,
  input  logic signed [31:0] in_width_den,
  input  logic signed [31:0] in_height_num,
  input  logic signed [31:0] in_height_den,
  input  logic signed [31:0] in_hoff_num,
  input  logic signed [31:0] in_hoff_den,
  input  logic signed [31:0] in_voff_num,
  input  logic signed [31:0] in_voff_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_valid_res,
  output logic [30:0]        out_left_edge,
  output logic [30:0]        out_top_edge,
  output logic [30:0]        out_right_edge,
  output logic [30:0]        out_bottom_edge
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_t state_r, div_ret_r, red_ret_r;
  logic   out_valid_r;

  // Shared restoring divider: quotient shifts in from the dividend side
  logic [4:0]  div_cnt_r;
  logic [31:0] div_quo_r, div_rem_r, div_dsr_r;

  // Latched item
  logic [31:0]        iw_r, ih_r;
  logic signed [31:0] wn_r, wd_r, hn_r, hd_r, hon_r, hod_r, von_r, vod_r;

  // Working fractions: c = running edge, x = other term / reduce target
  logic signed [31:0] cn_r, cd_r, xn_r, xd_r;
  logic signed [31:0] pn_r, qn_r, pd_r;
  logic signed [63:0] prod_r;
  logic [31:0]        ga_r, gb_r;   // Euclid pair, ga holds the GCD at the end
  logic [30:0]        cw_r, ch_r, left_r, top_r;
  logic               axis_r;       // 0 = horizontal, 1 = vertical
  logic               sub_r;        // second combine subtracts half size
  logic               res_ok_r;

  // Output holding register
  logic        o_res_r;
  logic [30:0] o_left_r, o_top_r, o_right_r, o_bottom_r;

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic [32:0] rem_sh;
  logic [33:0] rem_diff;
  assign rem_sh   = {div_rem_r, div_quo_r[31]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, div_dsr_r};

  logic [31:0] xn_mag;
  assign xn_mag = xn_r[31] ? 32'(-xn_r) : xn_r;

  // one 32x32 signed multiplier, result registered before any use
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  always_comb begin
    unique case (state_r)
      S_M0:    begin mul_a = cn_r; mul_b = xd_r; end
      S_M1:    begin mul_a = xn_r; mul_b = cd_r; end
      default: begin mul_a = cd_r; mul_b = xd_r; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic prod_fits;
  assign prod_fits = (prod_r[63:31] == '0) || (&prod_r[63:31]);

  // per-axis operands
  logic [30:0]        full_sel, size_sel;
  logic signed [31:0] off_n, off_d;
  assign full_sel = axis_r ? ih_r[30:0] : iw_r[30:0];
  assign size_sel = axis_r ? ch_r : cw_r;
  assign off_n    = axis_r ? von_r : hon_r;
  assign off_d    = axis_r ? vod_r : hod_r;

  // combine sum / difference with overflow detect
  logic [32:0] sum33;
  assign sum33 = sub_r ? ({pn_r[31], pn_r} - {qn_r[31], qn_r})
                       : ({pn_r[31], pn_r} + {qn_r[31], qn_r});

  logic [31:0] right_sum, bottom_sum;
  assign right_sum  = {1'b0, left_r} + {1'b0, cw_r};
  assign bottom_sum = {1'b0, top_r} + {1'b0, ch_r};

  logic bad_den;
  assign bad_den = (wd_r <= 0) || (hd_r <= 0) || (hod_r <= 0) || (vod_r <= 0) ||
                   wn_r[31] || hn_r[31] || iw_r[31] || ih_r[31];

  // result staged this cycle: output slot empty or its beat leaving now
  logic done_fire;
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            iw_r  <= in_image_width;
            ih_r  <= in_image_height;
            wn_r  <= in_width_num;
            wd_r  <= in_width_den;
            hn_r  <= in_height_num;
            hd_r  <= in_height_den;
            hon_r <= in_hoff_num;
            hod_r <= in_hoff_den;
            von_r <= in_voff_num;
            vod_r <= in_voff_den;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (bad_den) begin
            res_ok_r <= 1'b0;
            state_r  <= S_DONE;
          end else begin
            div_quo_r <= wn_r;
            div_rem_r <= '0;
            div_dsr_r <= wd_r;
            div_cnt_r <= DIV_LAST_STEP;
            div_ret_r <= S_CW_CHK;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          div_quo_r <= {div_quo_r[30:0], ~rem_diff[33]};
          div_rem_r <= rem_diff[33] ? rem_sh[31:0] : rem_diff[31:0];
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == '0) begin
            state_r <= div_ret_r;
          end
        end
        S_CW_CHK: begin
          if (div_rem_r != '0 || div_quo_r == '0) begin
            res_ok_r <= 1'b0;
            state_r  <= S_DONE;
          end else begin
            cw_r      <= div_quo_r[30:0];
            div_quo_r <= hn_r;
            div_rem_r <= '0;
            div_dsr_r <= hd_r;
            div_cnt_r <= DIV_LAST_STEP;
            div_ret_r <= S_CH_CHK;
            state_r   <= S_DIV;
          end
        end
        S_CH_CHK: begin
          if (div_rem_r != '0 || div_quo_r == '0) begin
            res_ok_r <= 1'b0;
            state_r  <= S_DONE;
          end else begin
            ch_r    <= div_quo_r[30:0];
            axis_r  <= 1'b0;
            state_r <= S_EDGE_INIT;
          end
        end
        // centre = full/2 in lowest terms, then reduce the offset
        S_EDGE_INIT: begin
          if (!full_sel[0]) begin
            cn_r <= {2'b00, full_sel[30:1]};
            cd_r <= 32'sd1;
          end else begin
            cn_r <= {1'b0, full_sel};
            cd_r <= 32'sd2;
          end
          xn_r      <= off_n;
          xd_r      <= off_d;
          sub_r     <= 1'b0;
          red_ret_r <= S_COMB;
          state_r   <= S_R_INIT;
        end
        // Euclid reduce of (xn, xd); xd is always positive here
        S_R_INIT: begin
          ga_r    <= xn_mag;
          gb_r    <= xd_r;
          state_r <= S_R_LOOP;
        end
        S_R_LOOP: begin
          if (gb_r == '0) begin
            if (ga_r > 32'd1) begin
              div_quo_r <= xn_mag;
              div_rem_r <= '0;
              div_dsr_r <= ga_r;
              div_cnt_r <= DIV_LAST_STEP;
              div_ret_r <= S_R_N;
              state_r   <= S_DIV;
            end else begin
              state_r <= red_ret_r;
            end
          end else begin
            div_quo_r <= ga_r;
            div_rem_r <= '0;
            div_dsr_r <= gb_r;
            div_cnt_r <= DIV_LAST_STEP;
            div_ret_r <= S_R_STEP;
            state_r   <= S_DIV;
          end
        end
        S_R_STEP: begin
          ga_r    <= gb_r;
          gb_r    <= div_rem_r;
          state_r <= S_R_LOOP;
        end
        S_R_N: begin
          xn_r      <= xn_r[31] ? -$signed(div_quo_r) : $signed(div_quo_r);
          div_quo_r <= xd_r;
          div_rem_r <= '0;
          div_dsr_r <= ga_r;
          div_cnt_r <= DIV_LAST_STEP;
          div_ret_r <= S_R_D;
          state_r   <= S_DIV;
        end
        S_R_D: begin
          xd_r    <= div_quo_r;
          state_r <= red_ret_r;
        end
        // bring c and x to a common denominator
        S_COMB: begin
          if (cd_r == xd_r) begin
            pn_r    <= cn_r;
            qn_r    <= xn_r;
            pd_r    <= cd_r;
            state_r <= S_SUM;
          end else begin
            state_r <= S_M0;
          end
        end
        S_M0: begin
          prod_r  <= mul_p;
          state_r <= S_M1;
        end
        S_M1: begin
          if (!prod_fits) begin
            res_ok_r <= 1'b0;
            state_r  <= S_DONE;
          end else begin
            pn_r    <= prod_r[31:0];
            prod_r  <= mul_p;
            state_r <= S_M2;
          end
        end
        S_M2: begin
          if (!prod_fits) begin
            res_ok_r <= 1'b0;
            state_r  <= S_DONE;
          end else begin
            qn_r    <= prod_r[31:0];
            prod_r  <= mul_p;
            state_r <= S_M3;
          end
        end
        S_M3: begin
          if (!prod_fits) begin
            res_ok_r <= 1'b0;
            state_r  <= S_DONE;
          end else begin
            pd_r    <= prod_r[31:0];
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          if (sum33[32] != sum33[31]) begin
            res_ok_r <= 1'b0;
            state_r  <= S_DONE;
          end else begin
            xn_r      <= sum33[31:0];
            xd_r      <= pd_r;
            red_ret_r <= S_AFTER;
            state_r   <= S_R_INIT;
          end
        end
        S_AFTER: begin
          cn_r <= xn_r;
          cd_r <= xd_r;
          if (!sub_r) begin
            // half size, already in lowest terms
            sub_r <= 1'b1;
            if (!size_sel[0]) begin
              xn_r <= {2'b00, size_sel[30:1]};
              xd_r <= 32'sd1;
            end else begin
              xn_r <= {1'b0, size_sel};
              xd_r <= 32'sd2;
            end
            state_r <= S_COMB;
          end else if (xd_r == 32'sd1 && !xn_r[31]) begin
            if (!axis_r) begin
              left_r  <= xn_r[30:0];
              axis_r  <= 1'b1;
              state_r <= S_EDGE_INIT;
            end else begin
              top_r   <= xn_r[30:0];
              state_r <= S_FINAL;
            end
          end else begin
            res_ok_r <= 1'b0;
            state_r  <= S_DONE;
          end
        end
        S_FINAL: begin
          res_ok_r <= (right_sum <= iw_r) && (bottom_sum <= ih_r);
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            o_res_r     <= res_ok_r;
            o_left_r    <= res_ok_r ? left_r : '0;
            o_top_r     <= res_ok_r ? top_r : '0;
            o_right_r   <= res_ok_r ? right_sum[30:0] : '0;
            o_bottom_r  <= res_ok_r ? bottom_sum[30:0] : '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_valid_res   = o_res_r;
  assign out_left_edge   = o_left_r;
  assign out_top_edge    = o_top_r;
  assign out_right_edge  = o_right_r;
  assign out_bottom_edge = o_bottom_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_res_r) |-> (o_left_r == '0 && o_top_r == '0 &&
                                   o_right_r == '0 && o_bottom_r == '0))
    else $error("failed result carries nonzero edges");

  a_rect_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_res_r) |-> (o_right_r > o_left_r && o_bottom_r > o_top_r))
    else $error("valid rectangle is empty");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_dsr_r != '0))
    else $error("divider started with zero divisor");

  a_done_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_CHK))
    else $error("accepted beat not checked");

endmodule
